### rtl/core/vss_pkg.sv
// vss_pkg: request and response payload types, command and status codes
// for the versioned sparse set; no dependencies
`default_nettype none

package vss_pkg;

    localparam int CMD_W    = 3;
    localparam int ID_W     = 32;
    localparam int POS_W    = 12;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 13;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SWAP   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] pos_a;
        logic [POS_W-1:0] pos_b;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [ID_W-1:0]     id_out;
        logic [COUNT_W-1:0]  count;
    } rsp_t;

endpackage

`default_nettype wire

### rtl/core/versioned_sparse_set_top.sv
// versioned_sparse_set_top: sparse set of versioned ids with sparse and dense stores
// depends on vss_pkg (types, codes) and vss_ram (both stores)
//
// One request in, one response out. A request is taken only while the sequencer is
// idle, but a finished response may still sit in the output register waiting to be
// taken, and a finished request waits while the output register is still full. A
// request runs a chain of dependent accesses through the single read port of each
// store: sparse position, then dense entry, then (for remove) the last entry, then
// write-back; read fetches one dense entry, swap fetches both entries unless a
// position is bad or both positions are equal, and clear and unused codes skip both.
// Neither store is cleared after reset: a sparse entry is trusted only when it lies
// below the member count and the dense entry there carries the same index, and
// clear just zeroes the count, so the block accepts requests right after reset.
`default_nettype none

module versioned_sparse_set_top #(
    parameter int INDEX_BITS = 12,
    parameter int ID_WIDTH   = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    output logic              req_ready,
    input  wire vss_pkg::req_t req_data,
    output logic              rsp_valid,
    input  wire logic         rsp_ready,
    output vss_pkg::rsp_t     rsp_data
);

    import vss_pkg::*;

    localparam int DEPTH = 1 << INDEX_BITS;
    localparam int PW    = INDEX_BITS;
    localparam int CW    = INDEX_BITS + 1;
    // compare width for request positions against the count
    localparam int CMPW  = (CW > POS_W) ? CW : POS_W;
    // width in which positions and counts are cut down to the response fields
    localparam int OW    = (CW > COUNT_W) ? CW : COUNT_W;
    // width in which ids are extended before fields or index bits are taken
    localparam int XW0   = (ID_WIDTH > INDEX_BITS) ? ID_WIDTH : INDEX_BITS;
    localparam int XW    = (XW0 > ID_W) ? XW0 : ID_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SPARSE = 6'b000010,
        S_DENSE  = 6'b000100,
        S_SWAP_B = 6'b001000,
        S_SWAP_W = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    // sequencer control
    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                rsp_valid_reg, rsp_valid_next;

    // captured request and intermediate results
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [ID_WIDTH-1:0] v_reg, v_next;
    logic [PW-1:0]       idx_reg, idx_next;
    logic [PW-1:0]       a_reg, a_next;
    logic [PW-1:0]       b_reg, b_next;
    logic                bad_reg, bad_next;
    logic [PW-1:0]       p_reg, p_next;
    logic                p_ok_reg, p_ok_next;
    logic                match_reg, match_next;
    logic [ID_WIDTH-1:0] va_reg, va_next;
    rsp_t                rsp_data_reg, rsp_data_next;

    // store ports
    logic                sp_we, sp_re;
    logic [PW-1:0]       sp_waddr, sp_raddr, sp_wdata, sp_rdata;
    logic                dn_we, dn_re;
    logic [PW-1:0]       dn_waddr, dn_raddr;
    logic [ID_WIDTH-1:0] dn_wdata, dn_rdata;

    // request decode
    logic [XW-1:0]       req_id_x;
    logic [ID_WIDTH-1:0] v_in;
    logic [XW-1:0]       v_in_x;
    logic [PW-1:0]       idx_in;
    logic [CMPW-1:0]     a_x, b_x, cnt_x;

    // index bits of dense read data and of the first swap operand
    logic [XW-1:0]       rd_x, va_x;
    logic [PW-1:0]       rd_idx, va_idx;

    logic [CW-1:0]       last_full;
    logic                out_free;

    // response assembly
    logic [STATUS_W-1:0] st_val;
    logic [PW-1:0]       pos_val;
    logic [ID_WIDTH-1:0] id_val;
    logic [OW-1:0]       pos_o, cnt_o;
    logic [XW-1:0]       id_o;

    vss_ram #(
        .WIDTH (PW),
        .DEPTH (DEPTH)
    ) u_sparse (
        .clk   (clk),
        .we    (sp_we),
        .waddr (sp_waddr),
        .wdata (sp_wdata),
        .re    (sp_re),
        .raddr (sp_raddr),
        .rdata (sp_rdata)
    );

    vss_ram #(
        .WIDTH (ID_WIDTH),
        .DEPTH (DEPTH)
    ) u_dense (
        .clk   (clk),
        .we    (dn_we),
        .waddr (dn_waddr),
        .wdata (dn_wdata),
        .re    (dn_re),
        .raddr (dn_raddr),
        .rdata (dn_rdata)
    );

    // ids are held at ID_WIDTH bits; the index is taken after zero extension
    assign req_id_x  = XW'(req_data.id);
    assign v_in      = req_id_x[ID_WIDTH-1:0];
    assign v_in_x    = XW'(v_in);
    assign idx_in    = v_in_x[PW-1:0];
    assign a_x       = CMPW'(req_data.pos_a);
    assign b_x       = CMPW'(req_data.pos_b);
    assign cnt_x     = CMPW'(count_reg);

    assign rd_x      = XW'(dn_rdata);
    assign rd_idx    = rd_x[PW-1:0];
    assign va_x      = XW'(va_reg);
    assign va_idx    = va_x[PW-1:0];

    assign last_full = count_reg - CW'(1);
    assign out_free  = !rsp_valid_reg || rsp_ready;

    assign pos_o     = OW'(pos_val);
    assign cnt_o     = OW'(count_next);
    assign id_o      = XW'(id_val);

    // only one request in flight; the output register lets the next one in early
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_data_next  = rsp_data_reg;
        cmd_next       = cmd_reg;
        v_next         = v_reg;
        idx_next       = idx_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        bad_next       = bad_reg;
        p_next         = p_reg;
        p_ok_next      = p_ok_reg;
        match_next     = match_reg;
        va_next        = va_reg;

        sp_we    = 1'b0;
        sp_waddr = '0;
        sp_wdata = '0;
        sp_re    = 1'b0;
        sp_raddr = '0;
        dn_we    = 1'b0;
        dn_waddr = '0;
        dn_wdata = '0;
        dn_re    = 1'b0;
        dn_raddr = '0;

        st_val  = ST_OK;
        pos_val = '0;
        id_val  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next = req_data.cmd;
                    v_next   = v_in;
                    idx_next = idx_in;
                    a_next   = a_x[PW-1:0];
                    b_next   = b_x[PW-1:0];
                    case (req_data.cmd)
                        CMD_INSERT, CMD_REMOVE, CMD_LOOKUP:
                        begin
                            // fetch the candidate dense position for this index
                            sp_re      = 1'b1;
                            sp_raddr   = idx_in;
                            state_next = S_SPARSE;
                        end
                        CMD_READ:
                        begin
                            bad_next   = (a_x >= cnt_x);
                            dn_re      = 1'b1;
                            dn_raddr   = a_x[PW-1:0];
                            state_next = S_FINISH;
                        end
                        CMD_SWAP:
                        begin
                            bad_next = (a_x >= cnt_x) || (b_x >= cnt_x);
                            if (!((a_x >= cnt_x) || (b_x >= cnt_x)) && (a_x != b_x))
                            begin
                                dn_re      = 1'b1;
                                dn_raddr   = a_x[PW-1:0];
                                state_next = S_SWAP_B;
                            end
                            else
                            begin
                                state_next = S_FINISH;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_SPARSE:
            begin
                // sparse entry is trusted only below the count
                p_next     = sp_rdata;
                p_ok_next  = (CW'(sp_rdata) < count_reg);
                dn_re      = 1'b1;
                dn_raddr   = sp_rdata;
                state_next = (cmd_reg == CMD_REMOVE) ? S_DENSE : S_FINISH;
            end

            S_DENSE:
            begin
                // remove: check exact id, then fetch the last member
                match_next = p_ok_reg && (dn_rdata == v_reg);
                dn_re      = 1'b1;
                dn_raddr   = last_full[PW-1:0];
                state_next = S_FINISH;
            end

            S_SWAP_B:
            begin
                va_next    = dn_rdata;
                dn_re      = 1'b1;
                dn_raddr   = b_reg;
                state_next = S_SWAP_W;
            end

            S_SWAP_W:
            begin
                // first half of the swap: entry b moves to a
                dn_we      = 1'b1;
                dn_waddr   = a_reg;
                dn_wdata   = dn_rdata;
                sp_we      = 1'b1;
                sp_waddr   = rd_idx;
                sp_wdata   = a_reg;
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                // writes and the response wait together for a free output register
                if (out_free)
                begin
                    case (cmd_reg)
                        CMD_INSERT:
                        begin
                            if (p_ok_reg && (rd_idx == idx_reg))
                            begin
                                if (dn_rdata == v_reg)
                                begin
                                    st_val = ST_MISS;
                                end
                                else
                                begin
                                    // same index, new version: replace in place
                                    dn_we    = 1'b1;
                                    dn_waddr = p_reg;
                                    dn_wdata = v_reg;
                                    pos_val  = p_reg;
                                end
                            end
                            else if (count_reg[PW])
                            begin
                                st_val = ST_FULL;
                            end
                            else
                            begin
                                // append at the end
                                dn_we      = 1'b1;
                                dn_waddr   = count_reg[PW-1:0];
                                dn_wdata   = v_reg;
                                sp_we      = 1'b1;
                                sp_waddr   = idx_reg;
                                sp_wdata   = count_reg[PW-1:0];
                                count_next = count_reg + CW'(1);
                                pos_val    = count_reg[PW-1:0];
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (match_reg)
                            begin
                                // last member fills the vacated slot
                                dn_we      = 1'b1;
                                dn_waddr   = p_reg;
                                dn_wdata   = dn_rdata;
                                sp_we      = 1'b1;
                                sp_waddr   = rd_idx;
                                sp_wdata   = p_reg;
                                count_next = last_full;
                                pos_val    = p_reg;
                            end
                            else
                            begin
                                st_val = ST_MISS;
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            if (p_ok_reg && (dn_rdata == v_reg))
                            begin
                                pos_val = p_reg;
                            end
                            else
                            begin
                                st_val = ST_MISS;
                            end
                        end
                        CMD_READ:
                        begin
                            if (bad_reg)
                            begin
                                st_val = ST_BADPOS;
                            end
                            else
                            begin
                                pos_val = a_reg;
                                id_val  = dn_rdata;
                            end
                        end
                        CMD_SWAP:
                        begin
                            if (bad_reg)
                            begin
                                st_val = ST_BADPOS;
                            end
                            else
                            begin
                                pos_val = a_reg;
                                if (a_reg != b_reg)
                                begin
                                    // second half: entry a moves to b
                                    dn_we    = 1'b1;
                                    dn_waddr = b_reg;
                                    dn_wdata = va_reg;
                                    sp_we    = 1'b1;
                                    sp_waddr = va_idx;
                                    sp_wdata = b_reg;
                                end
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase

                    rsp_valid_next         = 1'b1;
                    rsp_data_next.status   = st_val;
                    rsp_data_next.position = pos_o[POS_W-1:0];
                    rsp_data_next.id_out   = id_o[ID_W-1:0];
                    rsp_data_next.count    = cnt_o[COUNT_W-1:0];
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        v_reg        <= v_next;
        idx_reg      <= idx_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        bad_reg      <= bad_next;
        p_reg        <= p_next;
        p_ok_reg     <= p_ok_next;
        match_reg    <= match_next;
        va_reg       <= va_next;
        rsp_data_reg <= rsp_data_next;
    end

endmodule

`default_nettype wire

### rtl/core/vss_ram.sv
// vss_ram: generic simple dual-port ram, one write and one registered read
// per cycle; no dependencies
`default_nettype none

module vss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
